// ===== sv/svp_pkg.sv =====
`default_nettype none
package svp_pkg;

  // Defaults and fixed formats
  localparam int AXES_DEF       = 4;
  localparam int STEP_FRAC_BITS = 8;
  localparam int CFG_W          = 47;
  localparam int CFG_IDX_W      = 3;
  localparam int DIV_N_W        = 49;
  localparam int DIV_Q_W        = DIV_N_W + 32;

  localparam logic signed [63:0] LIM   = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [64:0] LIM65 = 65'sh0_3FFF_FFFF_FFFF_FFFF;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOL       = 3'd5;

  typedef struct packed {
    logic [2:0]         axis;
    logic signed [47:0] position_command;
    logic [31:0]        feedback_count;
  } svp_in_t;

  typedef struct packed {
    logic [2:0]         axis_out;
    logic signed [31:0] velocity_word;
    logic signed [63:0] feedback_position;
  } svp_out_t;

  // Which product the shared multiplier forms
  typedef enum logic [3:0] {
    OP_A0   = 4'd0,
    OP_VEL  = 4'd1,
    OP_CUR  = 4'd2,
    OP_EOUT = 4'd3,
    OP_ECMD = 4'd4,
    OP_STEP = 4'd5,
    OP_CORR = 4'd6,
    OP_RAMP = 4'd7,
    OP_WORD = 4'd8
  } mul_op_e;

  typedef struct packed {
    logic    capture;
    logic    load;
    logic    mul_start;
    mul_op_e mul_op;
    logic    div_start;
    logic    t_max;
    logic    take_vel;
    logic    commit;
  } svp_cmd_t;

  typedef struct packed {
    logic axis_ok;
    logic acc_zero;
    logic short_match;
    logic in_tol;
    logic mul_done;
    logic div_done;
    logic out_free;
  } svp_sts_t;

  function automatic logic signed [63:0] sat_lim(input logic signed [64:0] x);
    logic signed [63:0] r;
    if (x > LIM65) r = LIM;
    else if (x < -LIM65) r = -LIM;
    else r = x[63:0];
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return sat_lim({a[63], a} + {b[63], b});
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    return sat_lim({a[63], a} - {b[63], b});
  endfunction

  function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic logic signed [63:0] abs64(input logic signed [63:0] x);
    return (x < 0) ? -x : x;
  endfunction

endpackage
`default_nettype wire

// ===== sv/svp_mul.sv =====
`default_nettype none
// Signed 64x64 multiply, magnitude truncated, optional >>32, saturated to +-LIM.
// One 32x32 partial product per cycle.
module svp_mul (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  input  wire logic               sh32_i,
  output logic                    done_o,
  output logic signed [63:0]      res_o
);
  import svp_pkg::*;

  logic [63:0]  ua_q, ub_q;
  logic         neg_q, sh_q;
  logic [127:0] prod_q;
  logic [1:0]   cnt_q;
  logic         busy_q, done_q;

  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [6:0]   amt;
  logic [127:0] shifted;
  logic [63:0]  mag;

  // partial product select
  always_comb begin
    a_part  = cnt_q[0] ? ua_q[63:32] : ua_q[31:0];
    b_part  = cnt_q[1] ? ub_q[63:32] : ub_q[31:0];
    pp      = {32'b0, a_part} * {32'b0, b_part};
    amt     = {(2'(cnt_q[0]) + 2'(cnt_q[1])), 5'b0};
    shifted = sh_q ? {32'b0, prod_q[127:32]} : prod_q;
    mag     = (shifted > {64'b0, LIM}) ? LIM : shifted[63:0];
    res_o   = neg_q ? -$signed(mag) : $signed(mag);
  end

  assign done_o = done_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
      neg_q  <= a_i[63] ^ b_i[63];
      sh_q   <= sh32_i;
      prod_q <= '0;
    end else if (busy_q) begin
      prod_q <= prod_q + ({64'b0, pp} << amt);
    end
  end

endmodule
`default_nettype wire

// ===== sv/svp_div.sv =====
`default_nettype none
// Restoring divider: floor(n * 2^32 / d), saturated to LIM. One bit per cycle.
module svp_div (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [svp_pkg::DIV_N_W-1:0]     n_i,
  input  wire logic [62:0]                     d_i,
  output logic                                 done_o,
  output logic signed [63:0]                   q_o
);
  import svp_pkg::*;

  localparam int CNT_W = $clog2(DIV_Q_W + 1);

  logic [DIV_Q_W-1:0] num_q, quo_q;
  logic [62:0]        d_q;
  logic [63:0]        rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;

  logic [63:0] r2;
  logic        ge;

  always_comb begin
    r2  = {rem_q[62:0], num_q[DIV_Q_W-1]};
    ge  = r2 >= {1'b0, d_q};
    q_o = (|quo_q[DIV_Q_W-1:62]) ? LIM : $signed({2'b0, quo_q[61:0]});
  end

  assign done_o = done_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIV_Q_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift and subtract
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {n_i, 32'b0};
      d_q   <= d_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_Q_W-2:0], 1'b0};
      rem_q <= ge ? (r2 - {1'b0, d_q}) : r2;
      quo_q <= {quo_q[DIV_Q_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== sv/svp_ctrl.sv =====
`default_nettype none
// Sequencer: steps one word through the planner datapath.
module svp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire svp_pkg::svp_sts_t sts_i,
  output svp_pkg::svp_cmd_t      cmd_o
);
  import svp_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE = 13'b0000000000001,
    ST_LOAD = 13'b0000000000010,
    ST_A0   = 13'b0000000000100,
    ST_VEL  = 13'b0000000001000,
    ST_DIV  = 13'b0000000010000,
    ST_CUR  = 13'b0000000100000,
    ST_EOUT = 13'b0000001000000,
    ST_ECMD = 13'b0000010000000,
    ST_STEP = 13'b0000100000000,
    ST_CORR = 13'b0001000000000,
    ST_RAMP = 13'b0010000000000,
    ST_WORD = 13'b0100000000000,
    ST_OUT  = 13'b1000000000000
  } state_e;

  state_e  state_q, state_d, nxt;
  logic    wait_q, wait_d;
  logic    is_mul;
  mul_op_e op;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    wait_d  = wait_q;
    is_mul  = 1'b0;
    op      = OP_A0;
    nxt     = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = sts_i.axis_ok ? ST_A0 : ST_OUT;
      end
      ST_A0: begin
        is_mul = 1'b1; op = OP_A0; nxt = ST_VEL;
      end
      ST_VEL: begin
        is_mul = 1'b1; op = OP_VEL; nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.acc_zero) begin
          cmd_o.t_max = 1'b1;
          state_d     = ST_CUR;
        end else begin
          cmd_o.div_start = !wait_q;
          wait_d          = !sts_i.div_done;
          if (sts_i.div_done) state_d = ST_CUR;
        end
      end
      ST_CUR: begin
        is_mul = 1'b1; op = OP_CUR; nxt = ST_EOUT;
      end
      ST_EOUT: begin
        is_mul = 1'b1; op = OP_EOUT; nxt = ST_ECMD;
      end
      ST_ECMD: begin
        is_mul = 1'b1; op = OP_ECMD; nxt = ST_STEP;
      end
      ST_STEP: begin
        is_mul = 1'b1; op = OP_STEP;
        // match fits in one period: plain match or correction, else ramp
        if (sts_i.short_match) nxt = sts_i.in_tol ? ST_WORD : ST_CORR;
        else nxt = ST_RAMP;
        cmd_o.take_vel = sts_i.mul_done && sts_i.short_match && sts_i.in_tol;
      end
      ST_CORR: begin
        is_mul = 1'b1; op = OP_CORR; nxt = ST_WORD;
      end
      ST_RAMP: begin
        is_mul = 1'b1; op = OP_RAMP; nxt = ST_WORD;
      end
      ST_WORD: begin
        is_mul = 1'b1; op = OP_WORD; nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        wait_d  = 1'b0;
      end
    endcase

    // shared multiplier handshake
    if (is_mul) begin
      cmd_o.mul_op    = op;
      cmd_o.mul_start = !wait_q;
      wait_d          = !sts_i.mul_done;
      if (sts_i.mul_done) state_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wait_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/svp_dp.sv =====
`default_nettype none
// Planner datapath: config, per-axis state, shared multiplier, divider, output word.
module svp_dp #(
  parameter int AXES = svp_pkg::AXES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [svp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [svp_pkg::CFG_W-1:0]       cfg_data_i,
  input  wire svp_pkg::svp_in_t                in_word_i,
  input  wire svp_pkg::svp_cmd_t               cmd_i,
  output svp_pkg::svp_sts_t                    sts_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output svp_pkg::svp_out_t                    out_word_o
);
  import svp_pkg::*;

  localparam int AXW    = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int CUR_SH = (STEP_FRAC_BITS <= 16) ? 16 - STEP_FRAC_BITS : STEP_FRAC_BITS - 16;
  localparam logic signed [63:0] CUR_B = (STEP_FRAC_BITS <= 16) ? (64'sd1 <<< CUR_SH) : 64'sd1;

  // configuration
  logic [46:0] mv_q, ma_q;
  logic [31:0] dt_q, scale_q;
  logic [19:0] rate_q;
  logic [15:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q    <= '0;
      ma_q    <= '0;
      dt_q    <= 32'd4294967;
      rate_q  <= 20'd1000;
      scale_q <= 32'd65536;
      tol_q   <= 16'd7;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAX_VEL:   mv_q    <= cfg_data_i;
        REG_MAX_ACCEL: ma_q    <= cfg_data_i;
        REG_PERIOD:    dt_q    <= cfg_data_i[31:0];
        REG_RATE:      rate_q  <= cfg_data_i[19:0];
        REG_SCALE:     scale_q <= cfg_data_i[31:0];
        REG_TOL:       tol_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // per-axis state
  logic [31:0]        last_q  [AXES];
  logic [63:0]        accum_q [AXES];
  logic signed [47:0] cmdp_q  [AXES];
  logic signed [47:0] ov_q    [AXES];

  // working registers
  svp_in_t            in_q;
  logic [63:0]        acc_new_q;
  logic signed [63:0] pos_q, dpos_q, old_q;
  logic signed [63:0] acc_lim_q, vel_q, t_q, cur_q, eout_q, err_q, step_q, nv_q;
  logic signed [31:0] word_q;
  logic               out_valid_q;
  svp_out_t           out_q;

  logic [AXW-1:0]     ix;
  logic               axis_ok;
  logic [31:0]        d32;
  logic signed [63:0] pos_in;
  logic signed [63:0] mv64, ma64, dt64, rate64, scale64, tol64;
  logic signed [63:0] avg, tm, ramp_a, lo_b, hi_b, dv, dv_abs;
  logic [33:0]        dt3;
  logic signed [63:0] ma_a, mb_a, mres;
  logic               msh, mdone;
  logic signed [63:0] tq_div;
  logic               ddone;
  logic               s_pos, flip, s_eff;
  logic signed [63:0] nv_corr, nv_ramp, acc_lim_d, cur_d, w64;

  always_comb begin
    ix      = in_q.axis[AXW-1:0];
    axis_ok = {1'b0, in_q.axis} < 4'(AXES);
    d32     = in_q.feedback_count - last_q[ix];
    pos_in  = 64'(in_q.position_command);
    mv64    = $signed({17'b0, mv_q});
    ma64    = $signed({17'b0, ma_q});
    dt64    = $signed({32'b0, dt_q});
    rate64  = $signed({44'b0, rate_q});
    scale64 = $signed({32'b0, scale_q});
    tol64   = $signed({48'b0, tol_q});
    avg     = (vel_q + old_q) >>> 1;
    dt3     = {2'b0, dt_q} + {1'b0, dt_q, 1'b0};
    tm      = t_q - $signed({31'b0, dt3[33:1]});
    s_pos   = vel_q > old_q;
    ramp_a  = s_pos ? -(step_q <<< 1) : (step_q <<< 1);
    lo_b    = sat_sub(old_q, step_q);
    hi_b    = sat_add(old_q, step_q);
    dv      = vel_q - old_q;
    dv_abs  = abs64(dv);
  end

  // multiplier operand select
  always_comb begin
    ma_a = mv64; mb_a = rate64; msh = 1'b0;
    case (cmd_i.mul_op)
      OP_A0:   begin ma_a = mv64;      mb_a = rate64;  msh = 1'b0; end
      OP_VEL:  begin ma_a = dpos_q;    mb_a = rate64;  msh = 1'b0; end
      OP_CUR:  begin ma_a = acc_new_q; mb_a = CUR_B;   msh = 1'b0; end
      OP_EOUT: begin ma_a = avg;       mb_a = t_q;     msh = 1'b1; end
      OP_ECMD: begin ma_a = vel_q;     mb_a = tm;      msh = 1'b1; end
      OP_STEP: begin ma_a = acc_lim_q; mb_a = dt64;    msh = 1'b1; end
      OP_CORR: begin ma_a = err_q;     mb_a = rate64;  msh = 1'b0; end
      OP_RAMP: begin ma_a = ramp_a;    mb_a = t_q;     msh = 1'b1; end
      OP_WORD: begin ma_a = nv_q;      mb_a = scale64; msh = 1'b1; end
      default: ;
    endcase
  end

  svp_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (ma_a),
    .b_i     (mb_a),
    .sh32_i  (msh),
    .done_o  (mdone),
    .res_o   (mres)
  );

  svp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .n_i     (dv_abs[DIV_N_W-1:0]),
    .d_i     (acc_lim_q[62:0]),
    .done_o  (ddone),
    .q_o     (tq_div)
  );

  // result shaping per product
  always_comb begin
    acc_lim_d = (ma_q == '0 || ma64 > mres) ? mres : ma64;
    cur_d     = (STEP_FRAC_BITS <= 16) ? mres
                : clamp64($signed(acc_new_q) >>> CUR_SH, -LIM, LIM);
    nv_corr   = clamp64(clamp64(sat_sub(vel_q, mres >>> 1), lo_b, hi_b), -mv64, mv64);
    flip      = abs64(sat_add(err_q, sat_add(mres, mres))) < abs64(err_q);
    s_eff     = flip ? !s_pos : s_pos;
    nv_ramp   = clamp64(s_eff ? hi_b : lo_b, -mv64, mv64);
    w64       = clamp64(mres, -64'sd2147483648, 64'sd2147483647);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) in_q <= in_word_i;
    if (cmd_i.load) begin
      acc_new_q <= accum_q[ix] + {{32{d32[31]}}, d32};
      pos_q     <= pos_in;
      dpos_q    <= pos_in - 64'(cmdp_q[ix]);
      old_q     <= 64'(ov_q[ix]);
    end
    if (cmd_i.t_max) t_q <= LIM;
    if (ddone) t_q <= tq_div;
    if (cmd_i.take_vel) nv_q <= vel_q;
    if (mdone) begin
      case (cmd_i.mul_op)
        OP_A0:   acc_lim_q <= acc_lim_d;
        OP_VEL:  vel_q     <= clamp64(mres, -mv64, mv64);
        OP_CUR:  cur_q     <= cur_d;
        OP_EOUT: eout_q    <= sat_add(cur_q, mres);
        OP_ECMD: err_q     <= sat_sub(eout_q, sat_add(pos_q, mres));
        OP_STEP: step_q    <= mres;
        OP_CORR: nv_q      <= nv_corr;
        OP_RAMP: nv_q      <= nv_ramp;
        OP_WORD: word_q    <= w64[31:0];
        default: ;
      endcase
    end
  end

  // state write-back and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        last_q[i]  <= '0;
        accum_q[i] <= '0;
        cmdp_q[i]  <= '0;
        ov_q[i]    <= '0;
      end
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (axis_ok) begin
          last_q[ix]  <= in_q.feedback_count;
          accum_q[ix] <= acc_new_q;
          cmdp_q[ix]  <= pos_q[47:0];
          ov_q[ix]    <= nv_q[47:0];
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.axis_out          <= in_q.axis;
      out_q.velocity_word     <= axis_ok ? word_q : '0;
      out_q.feedback_position <= axis_ok ? $signed(acc_new_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    sts_o.axis_ok     = axis_ok;
    sts_o.acc_zero    = (acc_lim_q == '0);
    sts_o.short_match = t_q < dt64;
    sts_o.in_tol      = abs64(err_q) < tol64;
    sts_o.mul_done    = mdone;
    sts_o.div_done    = ddone;
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

endmodule
`default_nettype wire

// ===== sv/step_velocity_planner_unit.sv =====
// Step generator velocity planner, one axis per word.
// Input channel (in_valid_i / in_stall_o / in_word_i): axis, commanded position
// (Q32.16) and the raw 32-bit step counter. Output channel (out_valid_o /
// out_stall_i / out_word_o): axis, saturated velocity word and the 64-bit
// step accumulator; exactly one output word per input word, in order.
// Config port: cfg_we_i writes cfg_data_i to the register at cfg_index_i;
// write only while the block is idle. Unknown indexes are ignored.
// Words are processed one at a time; the next word is taken the cycle
// after the result is written. Each word passes the 81-step restoring
// divider for the match time (skipped when the computed acceleration limit
// is zero) and seven or eight products on the shared multiplier, four
// 32x32 partial products each.
// A word whose axis is beyond the configured axis count skips the planning
// steps, changes no state and reports zero velocity and position.
// The finished word sits in an output register, so the next input word is
// taken while a result is still stalled; a new result waits for that
// register to drain before it is written.
// Reset clears all per-axis state and loads the config defaults.
`default_nettype none
module step_velocity_planner_unit #(
  parameter int AXES = svp_pkg::AXES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [svp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [svp_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire svp_pkg::svp_in_t              in_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output svp_pkg::svp_out_t                  out_word_o
);
  import svp_pkg::*;

  svp_cmd_t cmd;
  svp_sts_t sts;

  svp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  svp_dp #(
    .AXES (AXES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import svp_pkg::*;

  localparam int NAX = AXES_DEF;
  localparam logic signed [63:0] I32MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32MIN = -64'sd2147483648;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 3000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  svp_in_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  svp_out_t out_word_o;

  step_velocity_planner_unit #(.AXES(NAX)) DUT (.*);

  always #6 clk_i = ~clk_i;

  // planner state mirror
  logic [63:0] max_vel_q, max_acc_q, period_q, rate_q, scale_q, tol_q;
  logic signed [63:0] cmd_pos[NAX];
  logic signed [63:0] out_vel[NAX];
  logic [63:0] step_acc[NAX];
  logic [31:0] last_cnt[NAX];

  // stimulus shadow of the last values sent per axis
  logic signed [47:0] cmd_shadow[8];
  logic [31:0] last_shadow[8];

  svp_in_t pending_words[$];
  svp_out_t expected_words[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  int hold_cnt = 0;
  bit in_taken = 0;

  function automatic logic signed [63:0] clampv(logic signed [63:0] x, logic signed [63:0] lo,
                                               logic signed [63:0] hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic logic signed [63:0] absv(logic signed [63:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic signed [63:0] ssum(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    return s > 65'(LIM) ? LIM : (s < -65'(LIM) ? -LIM : s[63:0]);
  endfunction

  function automatic logic signed [63:0] sdiff(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    return s > 65'(LIM) ? LIM : (s < -65'(LIM) ? -LIM : s[63:0]);
  endfunction

  // truncating product with shift, saturated to the internal limit
  function automatic logic signed [63:0] mulsh(logic signed [63:0] a, logic signed [63:0] b,
                                              int sh);
    logic [63:0] ua, ub, r;
    logic [127:0] p;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = ({64'd0, ua} * {64'd0, ub}) >> sh;
    r = (p[127:64] != 0 || p[63:0] > LIM) ? LIM : p[63:0];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] asr1(logic signed [63:0] x);
    return x >>> 1;
  endfunction

  function automatic logic [63:0] ramp_time(logic [63:0] n, logic [63:0] d);
    logic [127:0] q;
    q = {n, 32'd0} / {64'd0, d};
    return q >= (128'd1 << 62) ? LIM : q[63:0];
  endfunction

  function automatic svp_out_t plan_velocity(svp_in_t w);
    svp_out_t r;
    int ax;
    logic [31:0] d;
    logic signed [63:0] mv, rate, dt, a0, acc, pos, vel, old, dv, avg, cur;
    logic signed [63:0] eout, tm, ecmd, err, step, nv, dp, wv;
    logic [63:0] t;
    int s;
    r.axis_out = w.axis;
    r.velocity_word = '0;
    r.feedback_position = '0;
    ax = w.axis;
    if (ax >= NAX) return r;
    d = w.feedback_count - last_cnt[ax];
    last_cnt[ax] = w.feedback_count;
    step_acc[ax] = step_acc[ax] + {{32{d[31]}}, d};
    mv = max_vel_q; rate = rate_q; dt = period_q;
    a0 = mulsh(mv, rate, 0);
    acc = (max_acc_q == 0 || $signed(max_acc_q) > a0) ? a0 : $signed(max_acc_q);
    pos = {{16{w.position_command[47]}}, w.position_command};
    vel = clampv(mulsh(pos - cmd_pos[ax], rate, 0), -mv, mv);
    cmd_pos[ax] = pos;
    old = out_vel[ax];
    dv = vel - old;
    s = vel > old ? 1 : -1;
    t = acc == 0 ? LIM : ramp_time(absv(dv), acc);
    avg = asr1(vel + old);
    cur = mulsh($signed(step_acc[ax]), 64'sd1 << (16 - STEP_FRAC_BITS), 0);
    eout = ssum(cur, mulsh(avg, $signed(t), 32));
    tm = $signed(t) - $signed((period_q * 3) >> 1);
    ecmd = ssum(pos, mulsh(vel, tm, 32));
    err = sdiff(eout, ecmd);
    step = mulsh(acc, dt, 32);
    if ($signed(t) < dt) begin
      if (absv(err) < $signed(tol_q)) begin
        nv = vel;
      end else begin
        nv = sdiff(vel, asr1(mulsh(err, rate, 0)));
        nv = clampv(nv, sdiff(old, step), ssum(old, step));
      end
    end else begin
      dp = mulsh(s > 0 ? -2 * step : 2 * step, $signed(t), 32);
      if (absv(ssum(err, ssum(dp, dp))) < absv(err)) s = -s;
      nv = s > 0 ? ssum(old, step) : sdiff(old, step);
    end
    nv = clampv(nv, -mv, mv);
    out_vel[ax] = nv;
    wv = clampv(mulsh(nv, $signed(scale_q), 32), I32MIN, I32MAX);
    r.velocity_word = wv[31:0];
    r.feedback_position = step_acc[ax];
    return r;
  endfunction

  // input accept seen at the rising edge
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && !in_stall_o;
  end

  // driver: offers the next pending word, random gaps
  int gap = 0;
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (gap > 0) begin
        gap <= gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_word_i <= pending_words.pop_front();
        in_valid_i <= 1'b1;
        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 2);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall pattern, long hold-off counted here
  int stall_len = 0;
  always @(negedge clk_i) begin
    if (hold_off) begin
      out_stall_i <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else if (stall_len > 0) begin
      stall_len <= stall_len - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_len <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 300) : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: predict on accept, compare on result
  always @(posedge clk_i) begin
    svp_out_t exp_w;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid_i && !in_stall_o) begin
        expected_words.push_back(plan_velocity(in_word_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result word %h", out_word_o);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.axis_out !== out_word_o.axis_out ||
              exp_w.velocity_word !== out_word_o.velocity_word ||
              exp_w.feedback_position !== out_word_o.feedback_position) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp axis %0d vel %0d pos %0d, got axis %0d vel %0d pos %0d",
                       exp_w.axis_out, exp_w.velocity_word, exp_w.feedback_position,
                       out_word_o.axis_out, out_word_o.velocity_word,
                       out_word_o.feedback_position);
          end
        end
      end
      if (idle_cycles >= WATCHDOG && !hold_off) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAX_VEL:   max_vel_q = val & 64'h7FFF_FFFF_FFFF;
      REG_MAX_ACCEL: max_acc_q = val & 64'h7FFF_FFFF_FFFF;
      REG_PERIOD:    period_q = val & 64'hFFFF_FFFF;
      REG_RATE:      rate_q = val & 64'hF_FFFF;
      REG_SCALE:     scale_q = val & 64'hFFFF_FFFF;
      REG_TOL:       tol_q = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic svp_in_t rand_word(bit near);
    svp_in_t w;
    w.axis = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(NAX, 7))
                                         : 3'($urandom_range(0, NAX - 1));
    if (near) begin
      w.position_command = 48'(cmd_shadow[w.axis] + $signed(48'($urandom_range(0, 4000)) - 2000));
      w.feedback_count = 32'(last_shadow[w.axis] + $urandom_range(0, 200) - 100);
    end else begin
      w.position_command = 48'({$urandom(), $urandom()});
      w.feedback_count = $urandom();
    end
    if (w.axis < NAX) begin
      cmd_shadow[w.axis] = w.position_command;
      last_shadow[w.axis] = w.feedback_count;
    end
    return w;
  endfunction

  task automatic rand_phase(int n);
    for (int i = 0; i < n; i++)
      pending_words.push_back(rand_word($urandom_range(0, 4) != 0));
  endtask

  initial begin
    max_vel_q = 0; max_acc_q = 0; period_q = 4294967; rate_q = 1000;
    scale_q = 65536; tol_q = 7;
    for (int a = 0; a < NAX; a++) begin
      cmd_pos[a] = 0; out_vel[a] = 0; step_acc[a] = 0; last_cnt[a] = 0;
    end
    for (int a = 0; a < 8; a++) begin
      cmd_shadow[a] = 0; last_shadow[a] = 0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // defaults: zero velocity limit, zero accel
    pending_words.push_back('{axis: 3'd0, position_command: 48'sh7FFF_FFFF_FFFF,
                              feedback_count: 32'hFFFF_FFFF});
    pending_words.push_back('{axis: 3'd7, position_command: 48'sh8000_0000_0000,
                              feedback_count: 32'h8000_0000});
    drain();

    // directed: typical setting, field extremes, counter wrap
    write_reg(REG_MAX_VEL, 64'd1000 << 16);
    write_reg(REG_MAX_ACCEL, 64'd50000 << 16);
    write_reg(REG_PERIOD, 64'd4294967);
    write_reg(REG_RATE, 64'd1000);
    write_reg(REG_SCALE, 64'd65536);
    write_reg(REG_TOL, 64'd7);
    pending_words.push_back('{axis: 3'd1, position_command: 48'sd65536, feedback_count: 32'd0});
    pending_words.push_back('{axis: 3'd1, position_command: 48'sd65536, feedback_count: 32'd0});
    pending_words.push_back('{axis: 3'd1, position_command: 48'sh7FFF_FFFF_FFFF,
                              feedback_count: 32'h7FFF_FFFF});
    pending_words.push_back('{axis: 3'd1, position_command: 48'sh8000_0000_0000,
                              feedback_count: 32'h8000_0000});
    pending_words.push_back('{axis: 3'd2, position_command: -48'sd100,
                              feedback_count: 32'hFFFF_FFF0});
    pending_words.push_back('{axis: 3'd2, position_command: -48'sd100, feedback_count: 32'd16});
    pending_words.push_back('{axis: 3'd3, position_command: 48'sd0, feedback_count: 32'd5});
    pending_words.push_back('{axis: 3'd5, position_command: 48'sd1, feedback_count: 32'd5});
    for (int a = 0; a < 8; a++) begin
      cmd_shadow[a] = 0; last_shadow[a] = 0;
    end
    drain();

    // huge accumulator and word overflow: large counter jumps, big scale
    write_reg(REG_MAX_VEL, 64'h7FFF_FFFF_FFFF);
    write_reg(REG_MAX_ACCEL, 64'd0);
    write_reg(REG_SCALE, 64'hFFFF_FFFF);
    write_reg(REG_TOL, 64'hFFFF);
    for (int i = 0; i < 10; i++)
      pending_words.push_back('{axis: 3'd0, position_command: (i % 2) ? 48'sh7FFF_FFFF_FFFF :
                                48'sh8000_0000_0000, feedback_count: (i % 2) ? 32'h7FFF_FFFF :
                                32'hFFFF_FFFF});
    drain();

    // random phases across settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_MAX_VEL, 64'd2000 << 16); write_reg(REG_MAX_ACCEL, 64'd100000 << 16);
          write_reg(REG_PERIOD, 64'd4294967); write_reg(REG_RATE, 64'd1000);
          write_reg(REG_SCALE, 64'd65536); write_reg(REG_TOL, 64'd7);
        end
        1: begin
          write_reg(REG_PERIOD, 64'd1); write_reg(REG_RATE, 64'd1000000);
          write_reg(REG_TOL, 64'd0); write_reg(REG_SCALE, 64'd0);
        end
        2: begin
          write_reg(REG_PERIOD, 64'hFFFF_FFFF); write_reg(REG_RATE, 64'd1);
          write_reg(REG_MAX_ACCEL, 64'h7FFF_FFFF_FFFF); write_reg(REG_SCALE, 64'd1 << 20);
        end
        3: begin
          write_reg(REG_MAX_VEL, {$urandom(), $urandom()});
          write_reg(REG_MAX_ACCEL, 64'($urandom()));
          write_reg(REG_PERIOD, 64'($urandom_range(1, 32'hFFFF_FFFF)));
          write_reg(REG_RATE, 64'($urandom_range(1, 1000000)));
          write_reg(REG_SCALE, 64'($urandom()));
          write_reg(REG_TOL, 64'($urandom_range(0, 65535)));
        end
        4: begin
          write_reg(REG_MAX_VEL, 64'd0); write_reg(REG_MAX_ACCEL, 64'd0);
        end
        default: begin
          write_reg(REG_MAX_VEL, 64'd500 << 16); write_reg(REG_MAX_ACCEL, 64'd1000 << 16);
          write_reg(REG_PERIOD, 64'd42949673); write_reg(REG_RATE, 64'd100);
          write_reg(REG_SCALE, 64'd1 << 17); write_reg(REG_TOL, 64'd100);
        end
      endcase
      rand_phase(85);
      if (ph == 0) begin
        // long receiver hold-off while the sender keeps offering words
        hold_off = 1;
        wait (hold_cnt >= HOLD_CYCLES);
        hold_off = 0;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
